FILE: sv/sha512_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared types, constants and round functions for the stream hasher.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int WordW  = 64;
    localparam int BlkWds = 16;
    localparam int Rounds = 80;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  byte_count;
        logic        end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } t_out_item;

    localparam logic [63:0] IV_TAB [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] ror64(input logic [63:0] v, input int s);
        ror64 = (v >> s) | (v << (64 - s));
    endfunction

    function automatic logic [63:0] sig0(input logic [63:0] x);
        sig0 = ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] sig1(input logic [63:0] x);
        sig1 = ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
    endfunction

endpackage

FILE: sv/sha512_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-512 stream hasher
// Hashes a stream of big-endian 64-bit words and emits eight digest words.
// ----------------------------------------------------------------------------
// A data word is taken whenever o_stall is low; every sixteenth word starts an 80-round
// compression (one round per cycle, then an add into the hash), during which
// input stalls. The last word adds padding words, one per cycle while the core is
// idle, possibly running one extra block, then once the last compression ends
// the digest leaves as eight transactions, word_index 0 first.
module sha512_stream_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sha512_pkg::t_in_item  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sha512_pkg::t_out_item o_data
);
    import sha512_pkg::*;

    typedef enum logic [3:0] {
        ST_DATA = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_LEN  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state      r_state;
    logic [3:0]  r_pos;
    logic [63:0] r_len;
    logic [2:0]  r_oidx;
    logic        r_wait;
    logic        r_len_ok;
    logic        busy, clear, acc, wr, do_start, marker, out_acc;
    logic [63:0] wr_data, keep, n_len, addn;
    logic [63:0] hash [8];
    logic [3:0]  cnt;

    sha512_core u_core (
        .i_clk, .i_rst_n, .i_wr(wr), .i_wr_addr(r_pos), .i_wr_data(wr_data),
        .i_start(do_start), .i_clear(clear), .o_busy(busy), .o_hash(hash)
    );

    assign o_stall = (r_state != ST_DATA) || busy || r_wait;
    assign acc = i_valid && !o_stall;
    assign cnt = (!i_data.end_of_message) ? 4'd8 :
                 (i_data.byte_count > 4'd8) ? 4'd8 : i_data.byte_count;
    assign keep = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> (7'(cnt) * 7'd8));
    assign addn = 64'(cnt) << 3;
    assign n_len = (r_len > ~addn) ? 64'hffffffffffffffff : r_len + addn;

    always_comb begin
        wr = 1'b0;
        wr_data = '0;
        case (r_state)
            ST_DATA: begin
                wr = acc;
                if (cnt == 4'd8) wr_data = i_data.message_word;
                else wr_data = (i_data.message_word & keep) | (64'h80 << (7'd56 - 7'(cnt) * 7'd8));
            end
            ST_PAD: begin
                wr = !busy && !r_wait;
                wr_data = (r_pos == 4'd15 && r_len_ok) ? r_len : '0;
            end
            ST_LEN: begin
                wr = !busy && !r_wait;
                wr_data = 64'h8000000000000000;
            end
            default: ;
        endcase
    end
    assign do_start = wr && (r_pos == 4'd15);
    assign out_acc  = o_valid && !i_stall;
    assign clear    = out_acc && (r_oidx == 3'd7);
    // word holding the 0x80 pad byte
    assign marker = (r_state == ST_DATA && acc && i_data.end_of_message && cnt != 4'd8) ||
                    (r_state == ST_LEN && wr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_DATA;
            r_pos    <= '0;
            r_len    <= '0;
            r_oidx   <= '0;
            r_wait   <= 1'b0;
            r_len_ok <= 1'b0;
        end else begin
            r_wait <= do_start;
            if (wr) r_pos <= r_pos + 4'd1;
            // length may go into the next position-15 slot unless the pad byte sits at position 14
            if (marker) r_len_ok <= (r_pos != 4'd14);
            else if (r_state == ST_PAD && wr && r_pos == 4'd15) r_len_ok <= 1'b1;
            case (r_state)
                ST_DATA: if (acc) begin
                    r_len <= n_len;
                    if (i_data.end_of_message)
                        r_state <= (cnt == 4'd8) ? ST_LEN : ST_PAD;
                end
                ST_LEN: if (wr) r_state <= ST_PAD;
                ST_PAD: if (wr && r_pos == 4'd15 && r_len_ok) r_state <= ST_OUT;
                ST_OUT: if (out_acc) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_state <= ST_DATA;
                        r_len   <= '0;
                    end
                end
                default: r_state <= ST_DATA;
            endcase
        end
    end

    assign o_valid = (r_state == ST_OUT) && !busy;
    assign o_data.digest_word = hash[r_oidx];
    assign o_data.word_index  = r_oidx;
    assign o_data.digest_last = (r_oidx == 3'd7);
endmodule

FILE: sv/sha512_core.sv
// ----------------------------------------------------------------------------
// SHA-512 compression core
// Runs the 80 rounds over a 16-word block held in a synchronous memory;
// the schedule is rolled in place, one word per round, read-modify-write.
// ----------------------------------------------------------------------------
module sha512_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [3:0]  i_wr_addr,
    input  logic [63:0] i_wr_data,
    input  logic        i_start,
    input  logic        i_clear,
    output logic        o_busy,
    output logic [63:0] o_hash [8]
);
    import sha512_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_ADD  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [6:0]  r_rnd;
    logic [63:0] r_mem [BlkWds];
    logic [63:0] r_rd [4];
    logic [63:0] r_v [8];
    logic [63:0] r_h [8];
    logic [63:0] w_t, t1, t2;
    logic [3:0]  idx, ra;

    // reads for round t are issued during round t-1 (or at start for round 0):
    // slots t-16, t-15, t-7 and t-2; slot t-2 was written in round t-2
    assign idx = r_rnd[3:0];
    assign ra  = (r_state == ST_RUN) ? 4'(idx + 4'd1) : 4'd0;
    assign w_t = (r_rnd < 7'd16) ? r_rd[0] :
                 sig1(r_rd[3]) + r_rd[2] + sig0(r_rd[1]) + r_rd[0];

    assign t1 = r_v[7] + (ror64(r_v[4], 14) ^ ror64(r_v[4], 18) ^ ror64(r_v[4], 41)) +
                ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_rnd] + w_t;
    assign t2 = (ror64(r_v[0], 28) ^ ror64(r_v[0], 34) ^ ror64(r_v[0], 39)) +
                ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = ST_RUN;
            ST_RUN:  if (r_rnd == 7'(Rounds - 1)) n_state = ST_ADD;
            ST_ADD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) r_mem[idx] <= w_t;
        else if (i_wr) r_mem[i_wr_addr] <= i_wr_data;
        r_rd[0] <= r_mem[ra];
        r_rd[1] <= r_mem[4'(ra + 4'd1)];
        r_rd[2] <= r_mem[4'(ra + 4'd9)];
        r_rd[3] <= r_mem[4'(ra + 4'd14)];
        if (i_start) begin
            r_v <= r_h;
        end else if (r_state == ST_RUN) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_h     <= IV_TAB;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN) r_rnd <= r_rnd + 7'd1;
            else r_rnd <= '0;
            if (i_clear) r_h <= IV_TAB;
            else if (r_state == ST_ADD)
                for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_hash = r_h;
endmodule

FILE: sv/sha512_checker.sv
// ----------------------------------------------------------------------------
// SHA-512 port checker
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
module sha512_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input sha512_pkg::t_out_item o_data
);
    import sha512_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("output moved");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.digest_last != (o_data.word_index == 3'd7)) |-> 1'b0)
        else $error("bad last flag");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.digest_last |=> o_valid &&
        o_data.word_index == 3'($past(o_data.word_index) + 3'd1)) else $error("index gap");
    a_nooverlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken during digest");
endmodule

bind sha512_stream_hasher sha512_checker u_chk (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall, .o_data
);

FILE: tb/sv/tb_sha512_stream_hasher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-512 stream hasher testbench
// Sends directed and random messages with random idling and stalls, predicts
// each digest in a scoreboard and compares every digest transaction.
// ----------------------------------------------------------------------------
module tb_sha512_stream_hasher;
    import sha512_pkg::*;

    class digest_board;
        logic [63:0] hs [8];
        logic [63:0] blk [16];
        int unsigned pos;
        logic [63:0] nbits;
        t_out_item   want_q [$];
        int          errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            hs    = IV_TAB;
            pos   = 0;
            nbits = 64'd0;
        endfunction

        function logic [63:0] rotr(logic [63:0] v, int s);
            return (v >> s) | (v << (64 - s));
        endfunction

        function void compress();
            logic [63:0] w [80];
            logic [63:0] v [8];
            logic [63:0] x, y, t1, t2;
            for (int t = 0; t < 16; t++) w[t] = blk[t];
            for (int t = 16; t < 80; t++) begin
                x = w[t-15];
                y = w[t-2];
                w[t] = (rotr(y, 19) ^ rotr(y, 61) ^ (y >> 6)) + w[t-7]
                     + (rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7)) + w[t-16];
            end
            v = hs;
            for (int r = 0; r < 80; r++) begin
                t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
                t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int k = 0; k < 8; k++) hs[k] = hs[k] + v[k];
        endfunction

        function void load(logic [63:0] w);
            blk[pos] = w;
            pos = (pos + 1) % 16;
            if (pos == 0) compress();
        endfunction

        function void grow(logic [63:0] n);
            if (nbits > (64'hFFFF_FFFF_FFFF_FFFF - n)) nbits = 64'hFFFF_FFFF_FFFF_FFFF;
            else nbits = nbits + n;
        endfunction

        function void note_input(t_in_item it);
            int cnt;
            logic [63:0] keep;
            t_out_item o;
            if (!it.end_of_message) begin
                load(it.message_word);
                grow(64);
                return;
            end
            cnt = (it.byte_count > 8) ? 8 : int'(it.byte_count);
            grow(64'(cnt * 8));
            if (cnt == 8) begin
                load(it.message_word);
                load(64'h8000_0000_0000_0000);
            end else begin
                keep = (cnt == 0) ? 64'd0 : (~64'd0 << (64 - 8 * cnt));
                load((it.message_word & keep) | (64'h80 << (56 - 8 * cnt)));
            end
            while (pos != 14) load(64'd0);
            load(64'd0);
            load(nbits);
            for (int k = 0; k < 8; k++) begin
                o.digest_word = hs[k];
                o.word_index  = 3'(k);
                o.digest_last = (k == 7);
                want_q.push_back(o);
            end
            restart();
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item w;
            if (want_q.size() == 0) begin
                report("unexpected transaction", got.digest_word, 64'd0);
                return;
            end
            w = want_q.pop_front();
            if (got.digest_word !== w.digest_word) report("digest_word", got.digest_word, w.digest_word);
            if (got.word_index !== w.word_index) report("word_index", 64'(got.word_index),
                                                        64'(w.word_index));
            if (got.digest_last !== w.digest_last) report("digest_last", 64'(got.digest_last),
                                                          64'(w.digest_last));
        endtask
    endclass

    localparam int LIMIT = 300000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    digest_board sb = new();
    int  sent = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    bit  long_hold = 1'b0;
    int  stall_left = 0;

    sha512_stream_hasher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_input(i_data);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    // receiver: random stall bursts, one long hold on request
    always @(posedge i_clk) begin
        if (long_hold) begin
            long_hold  <= 1'b0;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task send_item(t_in_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    function logic [63:0] pick_word(int fill);
        case (fill)
            1: return 64'd0;
            2: return ~64'd0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task send_msg(int nwords, int last_cnt, int fill);
        t_in_item it;
        for (int i = 0; i < nwords; i++) begin
            it.message_word   = pick_word(fill);
            it.byte_count     = 4'($urandom_range(0, 15));
            it.end_of_message = 1'b0;
            send_item(it);
        end
        it.message_word   = pick_word(fill);
        it.byte_count     = 4'(last_cnt);
        it.end_of_message = 1'b1;
        send_item(it);
    endtask

    initial begin
        int n, msg;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_msg(0, 0, 1);
        send_msg(0, 8, 2);
        send_msg(0, 15, 2);
        send_msg(0, 1, 0);
        send_msg(0, 7, 0);
        send_msg(14, 0, 0);

        msg = 0;
        while (sent < 160) begin
            if (sent > 125) idle_on = 1'b0;
            case ($urandom_range(0, 5))
                0: n = 14;
                1: n = 15;
                2: n = $urandom_range(16, 32);
                default: n = $urandom_range(0, 13);
            endcase
            if (msg == 2) long_hold = 1'b1;
            send_msg(n, $urandom_range(0, 15), ($urandom_range(0, 9) == 0) ? 2 : 0);
            if (msg == 5) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (sb.want_q.size() != 0);
            end
            msg++;
        end
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.want_q.size() != 0);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.want_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: files.f
sv/sha512_pkg.sv
sv/sha512_core.sv
sv/sha512_stream_hasher.sv
sv/sha512_checker.sv
tb/sv/tb_sha512_stream_hasher.sv
